### hw/rtl/tcw_pkg.sv
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
   localparam int ADDR_WIDTH = $clog2(CELL_COUNT);
   localparam int COL_WIDTH  = $clog2(COLUMNS);
   localparam int ROW_WIDTH  = $clog2(ROWS);

   // field widths
   localparam int CMD_WIDTH        = 2;
   localparam int CHAR_WIDTH       = 8;
   localparam int CELL_INDEX_WIDTH = 11;
   localparam int ATTR_WIDTH       = 8;
   localparam int CELL_WIDTH       = ATTR_WIDTH + CHAR_WIDTH;
   localparam int CURSOR_ROW_WIDTH = 5;
   localparam int CURSOR_COL_WIDTH = 7;

   // tab stops
   localparam int TAB_STEP  = 8;
   localparam int TAB_WIDTH = $clog2(TAB_STEP + 1);

   // character and attribute codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_RETURN  = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [ATTR_WIDTH-1:0] RESET_ATTR   = 8'h0F;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd2;

   // decoupling queue
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CHAR_WIDTH-1:0]   char_code;
      logic [ADDR_WIDTH-1:0]   cell_addr;
   } item_type;

   typedef struct packed {
      logic                    full;
      logic                    empty;
      item_type                head;
   } queue_status_type;

endpackage

### hw/rtl/tcw_req_if.sv
interface tcw_req_if;
   import tcw_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CMD_WIDTH-1:0]        cmd;
   logic [CHAR_WIDTH-1:0]       char_code;
   logic [CELL_INDEX_WIDTH-1:0] cell_index;

   modport source (output valid, cmd, char_code, cell_index, input ready);
   modport sink (input valid, cmd, char_code, cell_index, output ready);
endinterface

### hw/rtl/tcw_rsp_if.sv
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CELL_WIDTH-1:0]       read_data;
   logic [CURSOR_ROW_WIDTH-1:0] cursor_row;
   logic [CURSOR_COL_WIDTH-1:0] cursor_col;
   logic                        did_scroll;

   modport source (output valid, read_data, cursor_row, cursor_col, did_scroll, input ready);
   modport sink (input valid, read_data, cursor_row, cursor_col, did_scroll, output ready);
endinterface

### hw/rtl/tcw_front.sv
module tcw_front (
   tcw_req_if.sink            req_bus,
   input  logic               init_busy,
   input  logic               queue_full,
   output logic               push,
   output tcw_pkg::item_type  push_item
);
   import tcw_pkg::*;

   // take a request whenever the queue has room and the screen is ready
   assign req_bus.ready = !queue_full && !init_busy;
   assign push          = req_bus.valid && req_bus.ready;

   // classify the request into a back-end operation
   always_comb begin
      push_item.char_code = req_bus.char_code;
      push_item.cell_addr = ADDR_WIDTH'(req_bus.cell_index);
      unique case (req_bus.cmd)
         CMD_PUT: begin
            priority if (req_bus.char_code == CHAR_NEWLINE) begin
               push_item.op = OP_NEWLINE;
            end else if (req_bus.char_code == CHAR_RETURN) begin
               push_item.op = OP_RETURN;
            end else if (req_bus.char_code == CHAR_TAB) begin
               push_item.op = OP_TAB;
            end else begin
               push_item.op = OP_PUT;
            end
         end
         CMD_CLEAR: begin
            push_item.op = OP_CLEAR;
         end
         CMD_READ: begin
            // a read past the screen answers like an unused command
            if (32'(req_bus.cell_index) < CELL_COUNT) begin
               push_item.op = OP_READ;
            end else begin
               push_item.op = OP_NOP;
            end
         end
         default: begin
            push_item.op = OP_NOP;
         end
      endcase
   end
endmodule

### hw/rtl/tcw_queue.sv
module tcw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tcw_pkg::item_type         push_item,
   input  logic                      pop,
   output tcw_pkg::queue_status_type status
);
   import tcw_pkg::*;

   item_type                     entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

### hw/rtl/tcw_back.sv
module tcw_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tcw_pkg::ATTR_WIDTH-1:0]  text_attribute,
   input  tcw_pkg::queue_status_type       queue_status,
   output logic                            pop,
   output logic                            init_busy,
   tcw_rsp_if.source                       rsp_bus
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_TAB,
      S_SCROLL,
      S_BLANK,
      S_CLEAR,
      S_READ,
      S_FINISH
   } state_type;

   state_type                   state_ff;
   logic [ADDR_WIDTH-1:0]       scan_ff;
   logic [COL_WIDTH-1:0]        cur_col_ff;
   logic [ROW_WIDTH-1:0]        cur_row_ff;
   logic [TAB_WIDTH-1:0]        tab_left_ff;
   logic [CELL_WIDTH-1:0]       pend_data_ff;
   logic                        pend_scroll_ff;
   logic                        rsp_valid_ff;
   logic [CELL_WIDTH-1:0]       rsp_data_ff;
   logic [CURSOR_ROW_WIDTH-1:0] rsp_row_ff;
   logic [CURSOR_COL_WIDTH-1:0] rsp_col_ff;
   logic                        rsp_scroll_ff;

   // screen memory
   logic [CELL_WIDTH-1:0]       cells_mem [CELL_COUNT];
   logic [CELL_WIDTH-1:0]       rd_data_ff;
   logic                        mem_we;
   logic [ADDR_WIDTH-1:0]       mem_waddr;
   logic [CELL_WIDTH-1:0]       mem_wdata;
   logic [ADDR_WIDTH-1:0]       mem_raddr;

   logic [ADDR_WIDTH-1:0]       cur_addr;
   logic [COL_WIDTH:0]          col_inc;
   logic [ROW_WIDTH:0]          row_inc;
   logic                        line_wrap;
   logic                        need_scroll;
   logic [COL_WIDTH:0]          tab_raw;
   logic [COL_WIDTH:0]          tab_stop;
   logic [TAB_WIDTH-1:0]        tab_count;
   logic                        out_free;

   assign init_busy = (state_ff == S_INIT);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // cursor address and advance
   assign cur_addr    = ADDR_WIDTH'(cur_row_ff) * ADDR_WIDTH'(COLUMNS) + ADDR_WIDTH'(cur_col_ff);
   assign col_inc     = {1'b0, cur_col_ff} + 1'b1;
   assign row_inc     = {1'b0, cur_row_ff} + 1'b1;
   assign line_wrap   = (col_inc == (COL_WIDTH + 1)'(COLUMNS));
   assign need_scroll = (row_inc == (ROW_WIDTH + 1)'(ROWS));

   // spaces up to the next tab stop, clipped at the line end
   assign tab_raw   = ({1'b0, cur_col_ff} + (COL_WIDTH + 1)'(TAB_STEP))
                      & ~((COL_WIDTH + 1)'(TAB_STEP - 1));
   assign tab_stop  = (tab_raw > (COL_WIDTH + 1)'(COLUMNS)) ? (COL_WIDTH + 1)'(COLUMNS) : tab_raw;
   assign tab_count = TAB_WIDTH'(tab_stop - {1'b0, cur_col_ff});

   // memory port control and queue pop
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = {text_attribute, CHAR_SPACE};
      mem_raddr = scan_ff + ADDR_WIDTH'(COLUMNS);
      pop       = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = {RESET_ATTR, CHAR_SPACE};
         end
         S_IDLE: begin
            if (!queue_status.empty) begin
               pop = 1'b1;
               if (queue_status.head.op == OP_PUT) begin
                  mem_we    = 1'b1;
                  mem_wdata = {text_attribute, queue_status.head.char_code};
               end
               if (queue_status.head.op == OP_READ) begin
                  mem_raddr = queue_status.head.cell_addr;
               end
            end
         end
         S_TAB: begin
            mem_we = 1'b1;
         end
         S_SCROLL: begin
            // copy the word read last cycle one row up
            if (scan_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = scan_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
         end
         S_BLANK, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells_mem[mem_raddr];
   end

   // sequencer, cursor and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         scan_ff        <= '0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         pend_scroll_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               if (scan_ff == ADDR_WIDTH'(CELL_COUNT - 1)) begin
                  scan_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (!queue_status.empty) begin
                  pend_data_ff   <= '0;
                  scan_ff        <= '0;
                  unique case (queue_status.head.op)
                     OP_PUT: begin
                        cur_col_ff <= line_wrap ? '0 : col_inc[COL_WIDTH-1:0];
                        if (line_wrap && need_scroll) begin
                           cur_row_ff     <= ROW_WIDTH'(ROWS - 1);
                           pend_scroll_ff <= 1'b1;
                           state_ff       <= S_SCROLL;
                        end else begin
                           if (line_wrap) begin
                              cur_row_ff <= row_inc[ROW_WIDTH-1:0];
                           end
                           state_ff <= S_FINISH;
                        end
                     end
                     OP_NEWLINE: begin
                        cur_col_ff <= '0;
                        if (need_scroll) begin
                           cur_row_ff     <= ROW_WIDTH'(ROWS - 1);
                           pend_scroll_ff <= 1'b1;
                           state_ff       <= S_SCROLL;
                        end else begin
                           cur_row_ff <= row_inc[ROW_WIDTH-1:0];
                           state_ff   <= S_FINISH;
                        end
                     end
                     OP_RETURN: begin
                        cur_col_ff <= '0;
                        state_ff   <= S_FINISH;
                     end
                     OP_TAB: begin
                        tab_left_ff <= tab_count;
                        state_ff    <= S_TAB;
                     end
                     OP_CLEAR: begin
                        cur_col_ff <= '0;
                        cur_row_ff <= '0;
                        state_ff   <= S_CLEAR;
                     end
                     OP_READ: begin
                        state_ff <= S_READ;
                     end
                     default: begin
                        state_ff <= S_FINISH;
                     end
                  endcase
               end
            end
            S_TAB: begin
               // one space a cycle; only the last one can reach the line end
               tab_left_ff <= tab_left_ff - 1'b1;
               cur_col_ff  <= line_wrap ? '0 : col_inc[COL_WIDTH-1:0];
               if (line_wrap && need_scroll) begin
                  cur_row_ff     <= ROW_WIDTH'(ROWS - 1);
                  pend_scroll_ff <= 1'b1;
                  scan_ff        <= '0;
                  state_ff       <= S_SCROLL;
               end else begin
                  if (line_wrap) begin
                     cur_row_ff <= row_inc[ROW_WIDTH-1:0];
                  end
                  if (tab_left_ff == TAB_WIDTH'(1)) begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SCROLL: begin
               if (scan_ff == ADDR_WIDTH'(MOVE_COUNT)) begin
                  state_ff <= S_BLANK;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_BLANK, S_CLEAR: begin
               if (scan_ff == ADDR_WIDTH'(CELL_COUNT - 1)) begin
                  scan_ff  <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_READ: begin
               pend_data_ff <= rd_data_ff;
               state_ff     <= S_FINISH;
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_data_ff    <= pend_data_ff;
                  rsp_row_ff     <= CURSOR_ROW_WIDTH'(cur_row_ff);
                  rsp_col_ff     <= CURSOR_COL_WIDTH'(cur_col_ff);
                  rsp_scroll_ff  <= pend_scroll_ff;
                  pend_scroll_ff <= 1'b0;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = rsp_data_ff;
   assign rsp_bus.cursor_row = rsp_row_ff;
   assign rsp_bus.cursor_col = rsp_col_ff;
   assign rsp_bus.did_scroll = rsp_scroll_ff;
endmodule

### hw/rtl/text_console_writer.sv
// channel   dir  handshake      payload
// req_bus   in   valid/ready    cmd, char_code, cell_index
// rsp_bus   out  valid/ready    read_data, cursor_row, cursor_col, did_scroll
// csr_*     in   write enable   text_attribute
//
// put, return, newline and unused commands go from idle to the finish state, a
// read passes the read state, a tab the tab state one space at a time; all go
// through the single screen memory. a scroll moves one cell per cycle, then
// blanks the bottom row; a clear blanks every cell. after reset a clearing pass
// over every cell blanks the screen while req_bus.ready stays low.
// a two-entry queue decouples the sides; a stalled response holds in its output register.
module text_console_writer (
   input  logic                           clock,
   input  logic                           reset,
   tcw_req_if.sink                        req_bus,
   tcw_rsp_if.source                      rsp_bus,
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::ATTR_WIDTH-1:0] csr_write_data
);
   import tcw_pkg::*;

   logic [ATTR_WIDTH-1:0] attr_ff;
   logic                  push;
   item_type              push_item;
   logic                  pop;
   logic                  init_busy;
   queue_status_type      queue_status;

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   tcw_front u_front (
      .req_bus    (req_bus),
      .init_busy  (init_busy),
      .queue_full (queue_status.full),
      .push       (push),
      .push_item  (push_item)
   );

   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .status    (queue_status)
   );

   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .queue_status   (queue_status),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_bus        (rsp_bus)
   );
endmodule

### tb/tb_text_console_writer.sv
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   // command code the block leaves unused
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 12_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 600;
   localparam int STREAM_ITEMS  = 400;
   localparam int INDEX_TOP     = (1 << CELL_INDEX_WIDTH) - 1;

   typedef struct packed {
      logic [CELL_WIDTH-1:0]       read_data;
      logic [CURSOR_ROW_WIDTH-1:0] cursor_row;
      logic [CURSOR_COL_WIDTH-1:0] cursor_col;
      logic                        did_scroll;
   } console_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [ATTR_WIDTH-1:0] csr_write_data;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the screen, cursor and attribute
   logic [CELL_WIDTH-1:0] screen_image [CELL_COUNT];
   int unsigned           cursor_col_now;
   int unsigned           cursor_row_now;
   logic [ATTR_WIDTH-1:0] attribute_now;

   // reports still owed by the block, oldest first
   console_report_type pending_reports [$];

   int fail_count    = 0;
   int send_idle_pct = 22;
   int recv_idle_pct = 72;
   int hold_ask      = 0;

   // screen shadow helpers
   function automatic void blank_screen();
      foreach (screen_image[i]) screen_image[i] = {attribute_now, CHAR_SPACE};
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < MOVE_COUNT; i++) screen_image[i] = screen_image[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) screen_image[MOVE_COUNT + c] = {attribute_now, CHAR_SPACE};
      cursor_row_now = ROWS - 1;
   endfunction

   function automatic bit line_feed();
      cursor_col_now = 0;
      cursor_row_now++;
      if (cursor_row_now >= ROWS) begin
         scroll_screen();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit store_cell(input logic [CHAR_WIDTH-1:0] ch);
      int unsigned addr;
      addr = cursor_row_now * COLUMNS + cursor_col_now;
      if (addr < CELL_COUNT) screen_image[addr] = {attribute_now, ch};
      cursor_col_now++;
      if (cursor_col_now >= COLUMNS) return line_feed();
      return 1'b0;
   endfunction

   // control codes, tab padding and plain bytes
   function automatic bit print_character(input logic [CHAR_WIDTH-1:0] ch);
      int unsigned stop;
      int unsigned pad;
      bit          scrolled;
      scrolled = 1'b0;
      if (ch == CHAR_NEWLINE) return line_feed();
      if (ch == CHAR_RETURN) begin
         cursor_col_now = 0;
         return 1'b0;
      end
      if (ch == CHAR_TAB) begin
         // tab near the line end stops at the last column and wraps once
         stop = (cursor_col_now + TAB_STEP) / TAB_STEP * TAB_STEP;
         if (stop > COLUMNS) stop = COLUMNS;
         pad = (stop > cursor_col_now) ? stop - cursor_col_now : 0;
         repeat (pad) begin
            if (store_cell(CHAR_SPACE)) scrolled = 1'b1;
         end
         return scrolled;
      end
      return store_cell(ch);
   endfunction

   function automatic console_report_type apply_console_command(
         input logic [CMD_WIDTH-1:0]        cmd,
         input logic [CHAR_WIDTH-1:0]       ch,
         input logic [CELL_INDEX_WIDTH-1:0] idx);
      console_report_type report;
      report = '0;
      case (cmd)
         CMD_PUT: begin
            report.did_scroll = print_character(ch);
         end
         CMD_CLEAR: begin
            blank_screen();
            cursor_col_now = 0;
            cursor_row_now = 0;
         end
         CMD_READ: begin
            if (idx < CELL_COUNT) report.read_data = screen_image[idx];
         end
         default: begin
         end
      endcase
      report.cursor_row = CURSOR_ROW_WIDTH'(cursor_row_now);
      report.cursor_col = CURSOR_COL_WIDTH'(cursor_col_now);
      return report;
   endfunction

   function automatic void check_field(input string name, input logic [CELL_WIDTH-1:0] want,
                                       input logic [CELL_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // one request, with random idle cycles ahead of it
   task automatic send_request(input logic [CMD_WIDTH-1:0]        cmd,
                               input logic [CHAR_WIDTH-1:0]       ch,
                               input logic [CELL_INDEX_WIDTH-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.char_code  <= ch;
      req_bus.cell_index <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_reports.push_back(apply_console_command(cmd, ch, idx));
   endtask

   task automatic wait_for_reports();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // attribute write, only with nothing in flight
   task automatic set_attribute(input logic [ATTR_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      attribute_now = value;
   endtask

   // mostly text with line control, some reads, clears and noise
   task automatic send_random_request();
      int unsigned                 pick;
      logic [CELL_INDEX_WIDTH-1:0] idx;
      pick = $urandom_range(999);
      idx  = CELL_INDEX_WIDTH'($urandom_range(INDEX_TOP));
      if (pick < 550)
         send_request(CMD_PUT, CHAR_WIDTH'($urandom_range(8'h7E, 8'h20)), idx);
      else if (pick < 630)
         send_request(CMD_PUT, CHAR_WIDTH'($urandom_range(255)), idx);
      else if (pick < 730)
         send_request(CMD_PUT, CHAR_NEWLINE, idx);
      else if (pick < 780)
         send_request(CMD_PUT, CHAR_RETURN, idx);
      else if (pick < 860)
         send_request(CMD_PUT, CHAR_TAB, idx);
      else if (pick < 920)
         send_request(CMD_READ, CHAR_WIDTH'($urandom_range(255)), idx);
      else if (pick < 975)
         send_request(CMD_READ, CHAR_WIDTH'($urandom_range(255)),
                      CELL_INDEX_WIDTH'(cursor_row_now * COLUMNS + $urandom_range(COLUMNS - 1)));
      else if (pick < 990)
         send_request(CMD_CLEAR, CHAR_WIDTH'($urandom_range(255)), idx);
      else
         send_request(CMD_UNUSED, CHAR_WIDTH'($urandom_range(255)), idx);
   endtask

   // screen contents after the reset clearing pass
   task automatic test_power_on_screen();
      send_request(CMD_READ, 8'h00, '0);
      send_request(CMD_READ, 8'h00, CELL_INDEX_WIDTH'(CELL_COUNT - 1));
      send_request(CMD_READ, 8'hFF, CELL_INDEX_WIDTH'(INDEX_TOP));
      send_request(CMD_UNUSED, 8'h00, CELL_INDEX_WIDTH'(INDEX_TOP));
   endtask

   task automatic test_control_codes();
      send_request(CMD_PUT, 8'h41, '0);
      send_request(CMD_PUT, 8'h00, '0);
      send_request(CMD_PUT, 8'hFF, '0);
      send_request(CMD_PUT, CHAR_TAB, '0);
      send_request(CMD_PUT, CHAR_RETURN, '0);
      send_request(CMD_PUT, CHAR_NEWLINE, '0);
   endtask

   task automatic test_tab_at_line_end();
      repeat (9) send_request(CMD_PUT, CHAR_TAB, '0);
      send_request(CMD_PUT, 8'h7E, '0);
      send_request(CMD_PUT, CHAR_TAB, '0);
      send_request(CMD_READ, 8'h00, CELL_INDEX_WIDTH'(COLUMNS + 72));
      send_request(CMD_READ, 8'h00, CELL_INDEX_WIDTH'(COLUMNS + COLUMNS - 1));
      wait_for_reports();
   endtask

   // blanks and writes take the attribute in force at the time
   task automatic test_blank_attribute();
      set_attribute(8'h00);
      send_request(CMD_CLEAR, 8'h00, '0);
      send_request(CMD_READ, 8'h00, CELL_INDEX_WIDTH'(CELL_COUNT - 1));
      wait_for_reports();
      set_attribute(8'hFF);
      send_request(CMD_PUT, 8'h5A, '0);
      send_request(CMD_READ, 8'h00, '0);
      wait_for_reports();
   endtask

   // receiver holds off while requests keep coming, then drain
   task automatic test_full_queue();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_ask++;
      repeat (12) send_request(CMD_PUT, CHAR_WIDTH'($urandom_range(8'h7E, 8'h20)), '0);
      wait_for_reports();
      send_idle_pct = saved_idle;
   endtask

   task automatic test_text_stream(input int count);
      repeat (count) send_random_request();
      wait_for_reports();
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: check each report, drive ready with idles and holds
   initial begin : response_side
      console_report_type got;
      console_report_type want;
      int unsigned        hold_left;
      int                 hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = {rsp_bus.read_data, rsp_bus.cursor_row, rsp_bus.cursor_col, rsp_bus.did_scroll};
            if (pending_reports.size() == 0) begin
               $error("response with no request outstanding: %0h", got);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("cursor_row", CELL_WIDTH'(want.cursor_row),
                           CELL_WIDTH'(got.cursor_row));
               check_field("cursor_col", CELL_WIDTH'(want.cursor_col),
                           CELL_WIDTH'(got.cursor_col));
               check_field("did_scroll", CELL_WIDTH'(want.did_scroll),
                           CELL_WIDTH'(got.did_scroll));
            end
         end
         if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // test sequence
   initial begin
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_PUT;
      req_bus.char_code  <= '0;
      req_bus.cell_index <= '0;
      attribute_now  = RESET_ATTR;
      cursor_col_now = 0;
      cursor_row_now = 0;
      blank_screen();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_power_on_screen();
      test_control_codes();
      test_tab_at_line_end();
      test_blank_attribute();
      test_full_queue();

      test_text_stream(STREAM_ITEMS);
      set_attribute(ATTR_WIDTH'($urandom_range(255)));
      send_idle_pct = 72;
      recv_idle_pct = 22;
      test_text_stream(STREAM_ITEMS);
      set_attribute(ATTR_WIDTH'($urandom_range(255)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_text_stream(STREAM_ITEMS);

      // let any stray response show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
